/* hw/rtl/ffha_pkg.sv */
package ffha_pkg;

  typedef enum logic [1:0] {
    FUNC_ALLOC = 2'd0,
    FUNC_FREE  = 2'd1,
    FUNC_READ  = 2'd2,
    FUNC_WRITE = 2'd3
  } func_t;

  typedef struct packed {
    func_t       func;
    logic [7:0]  request_words;
    logic [7:0]  location;
    logic [31:0] write_data;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  chunk_start;
    logic        ok;
    logic        corrupt;
    logic [31:0] read_data;
  } out_item_t;

  typedef enum logic [9:0] {
    S_CLEAR = 10'b00_0000_0001,
    S_IDLE  = 10'b00_0000_0010,
    S_ALLOC = 10'b00_0000_0100,
    S_SPLIT = 10'b00_0000_1000,
    S_FREE  = 10'b00_0001_0000,
    S_MREAD = 10'b00_0010_0000,
    S_MCHK  = 10'b00_0100_0000,
    S_MNEXT = 10'b00_1000_0000,
    S_MZERO = 10'b01_0000_0000,
    S_READ  = 10'b10_0000_0000
  } state_t;

endpackage

/* hw/rtl/ffha_store.sv */
module ffha_store #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* hw/rtl/first_fit_heap_allocator_top.sv */
// channel  ports                        direction  beat taken when
// cmd      start, busy, in_item         in         start && !busy
// result   out_valid, out_item          out        out_valid (one cycle, no stall)
//
// after reset a clearing pass writes every store word, with busy high
// write and out-of-range commands keep busy low; read holds busy while fetching
// allocate: walks headers from word 0 through the store port, with a split step
// free: clear the used flag, then rescan from word 0 and merge free neighbors
// each result beat shows in the cycle after the command ends, while the next is taken
module first_fit_heap_allocator_top #(
  parameter int HEAP_WORDS    = 256,
  parameter int WORD_BITS     = 32,
  parameter int USED_FLAG_BIT = 30,
  parameter int MARK_FLAG_BIT = 31
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  ffha_pkg::in_item_t  in_item,
  output logic                out_valid,
  output ffha_pkg::out_item_t out_item
);

  localparam int AW = $clog2(HEAP_WORDS);
  localparam int CW = ((WORD_BITS > AW + 1) ? WORD_BITS : AW + 1) + 2;
  localparam logic [WORD_BITS-1:0] USED_MASK = WORD_BITS'(1) << USED_FLAG_BIT;
  localparam logic [WORD_BITS-1:0] MARK_MASK = WORD_BITS'(1) << MARK_FLAG_BIT;
  localparam logic [WORD_BITS-1:0] LEN_MASK  = ~(USED_MASK | MARK_MASK);
  localparam logic [CW-1:0]        HEAP_CW   = CW'(HEAP_WORDS);
  localparam logic [WORD_BITS-1:0] INIT_HDR  =
    (WORD_BITS'(HEAP_WORDS) & LEN_MASK) | MARK_MASK;
  localparam logic [AW-1:0]        LAST_ADDR = AW'(HEAP_WORDS - 1);

  ffha_pkg::state_t    state_r, state_nxt;
  logic [AW-1:0]       pos_r, pos_nxt;
  logic [AW-1:0]       nxt_r, nxt_nxt;
  logic [WORD_BITS-1:0] hlen_r, hlen_nxt;
  logic [7:0]          req_r, req_nxt;
  logic                out_valid_r, out_valid_nxt;
  ffha_pkg::out_item_t out_item_r, out_item_nxt;

  logic                 wr_en;
  logic [AW-1:0]        wr_addr;
  logic [WORD_BITS-1:0] wr_data;
  logic                 rd_en;
  logic [AW-1:0]        rd_addr;
  logic [WORD_BITS-1:0] rd_q;

  logic [WORD_BITS-1:0] len_word;
  logic [CW-1:0]        len_w;
  logic [CW-1:0]        need_w;
  logic [CW-1:0]        room_w;
  logic [AW-1:0]        adv_addr;
  logic                 hdr_free;
  logic                 loc_ok;
  logic                 data_ok;
  logic [AW-1:0]        loc_addr;
  logic [AW-1:0]        data_addr;

  ffha_store #(
    .DEPTH (HEAP_WORDS),
    .WIDTH (WORD_BITS)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_q)
  );

  assign len_word  = rd_q & LEN_MASK;
  assign len_w     = CW'(len_word);
  assign need_w    = CW'(req_r) + CW'(1);
  assign room_w    = HEAP_CW - CW'(pos_r);
  assign adv_addr  = AW'(CW'(pos_r) + len_w);
  assign hdr_free  = ((rd_q & USED_MASK) == '0);
  assign loc_ok    = CW'(in_item.location) < HEAP_CW;
  assign data_ok   = (CW'(in_item.location) + CW'(1)) < HEAP_CW;
  assign loc_addr  = AW'(CW'(in_item.location));
  assign data_addr = AW'(CW'(in_item.location) + CW'(1));

  always_comb begin
    state_nxt     = state_r;
    pos_nxt       = pos_r;
    nxt_nxt       = nxt_r;
    hlen_nxt      = hlen_r;
    req_nxt       = req_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = '0;
    wr_en         = 1'b0;
    wr_addr       = pos_r;
    wr_data       = '0;
    rd_en         = 1'b0;
    rd_addr       = pos_r;
    case (state_r)
      ffha_pkg::S_CLEAR: begin
        wr_en   = 1'b1;
        wr_data = (pos_r == '0) ? INIT_HDR : '0;
        if (pos_r == LAST_ADDR) begin
          pos_nxt   = '0;
          state_nxt = ffha_pkg::S_IDLE;
        end else begin
          pos_nxt = pos_r + AW'(1);
        end
      end
      ffha_pkg::S_IDLE: begin
        if (start) begin
          req_nxt = in_item.request_words;
          case (in_item.func)
            ffha_pkg::FUNC_ALLOC: begin
              rd_en     = 1'b1;
              rd_addr   = '0;
              pos_nxt   = '0;
              state_nxt = ffha_pkg::S_ALLOC;
            end
            ffha_pkg::FUNC_FREE: begin
              if (loc_ok) begin
                rd_en     = 1'b1;
                rd_addr   = loc_addr;
                nxt_nxt   = loc_addr;
                state_nxt = ffha_pkg::S_FREE;
              end else begin
                out_valid_nxt = 1'b1;
              end
            end
            ffha_pkg::FUNC_READ: begin
              if (data_ok) begin
                rd_en     = 1'b1;
                rd_addr   = data_addr;
                state_nxt = ffha_pkg::S_READ;
              end else begin
                out_valid_nxt = 1'b1;
              end
            end
            ffha_pkg::FUNC_WRITE: begin
              wr_en           = data_ok;
              wr_addr         = data_addr;
              wr_data         = WORD_BITS'(in_item.write_data);
              out_valid_nxt   = 1'b1;
              out_item_nxt.ok = data_ok;
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end
      ffha_pkg::S_ALLOC: begin
        if (len_word == '0) begin
          out_valid_nxt        = 1'b1;
          out_item_nxt.corrupt = 1'b1;
          state_nxt            = ffha_pkg::S_IDLE;
        end else if (hdr_free && (len_w > need_w)) begin
          wr_en    = 1'b1;
          wr_data  = (WORD_BITS'(need_w) & LEN_MASK) | USED_MASK | MARK_MASK;
          hlen_nxt = len_word;
          if (need_w < room_w) begin
            state_nxt = ffha_pkg::S_SPLIT;
          end else begin
            out_valid_nxt            = 1'b1;
            out_item_nxt.ok          = 1'b1;
            out_item_nxt.chunk_start = 8'(pos_r);
            state_nxt                = ffha_pkg::S_IDLE;
          end
        end else if (len_w >= room_w) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ffha_pkg::S_IDLE;
        end else begin
          rd_en   = 1'b1;
          rd_addr = adv_addr;
          pos_nxt = adv_addr;
        end
      end
      ffha_pkg::S_SPLIT: begin
        wr_en   = 1'b1;
        wr_addr = AW'(CW'(pos_r) + need_w);
        wr_data = ((hlen_r - WORD_BITS'(need_w)) & LEN_MASK) | MARK_MASK;
        out_valid_nxt            = 1'b1;
        out_item_nxt.ok          = 1'b1;
        out_item_nxt.chunk_start = 8'(pos_r);
        state_nxt                = ffha_pkg::S_IDLE;
      end
      ffha_pkg::S_FREE: begin
        wr_en     = 1'b1;
        wr_addr   = nxt_r;
        wr_data   = rd_q & ~USED_MASK;
        pos_nxt   = '0;
        state_nxt = ffha_pkg::S_MREAD;
      end
      ffha_pkg::S_MREAD: begin
        rd_en     = 1'b1;
        state_nxt = ffha_pkg::S_MCHK;
      end
      ffha_pkg::S_MCHK: begin
        if (len_word == '0) begin
          out_valid_nxt        = 1'b1;
          out_item_nxt.corrupt = 1'b1;
          state_nxt            = ffha_pkg::S_IDLE;
        end else if (len_w < room_w) begin
          rd_en   = 1'b1;
          rd_addr = adv_addr;
          if (hdr_free) begin
            hlen_nxt  = len_word;
            nxt_nxt   = adv_addr;
            state_nxt = ffha_pkg::S_MNEXT;
          end else begin
            pos_nxt = adv_addr;
          end
        end else begin
          out_valid_nxt   = 1'b1;
          out_item_nxt.ok = 1'b1;
          state_nxt       = ffha_pkg::S_IDLE;
        end
      end
      ffha_pkg::S_MNEXT: begin
        if (!hdr_free) begin
          // next header already sits in the read register
          pos_nxt   = nxt_r;
          state_nxt = ffha_pkg::S_MCHK;
        end else if (len_word == '0) begin
          out_valid_nxt        = 1'b1;
          out_item_nxt.corrupt = 1'b1;
          state_nxt            = ffha_pkg::S_IDLE;
        end else begin
          wr_en     = 1'b1;
          wr_data   = ((hlen_r + len_word) & LEN_MASK) | MARK_MASK;
          state_nxt = ffha_pkg::S_MZERO;
        end
      end
      ffha_pkg::S_MZERO: begin
        wr_en     = 1'b1;
        wr_addr   = nxt_r;
        state_nxt = ffha_pkg::S_MREAD;
      end
      ffha_pkg::S_READ: begin
        out_valid_nxt          = 1'b1;
        out_item_nxt.ok        = 1'b1;
        out_item_nxt.read_data = 32'(rd_q);
        state_nxt              = ffha_pkg::S_IDLE;
      end
      default: begin
        state_nxt = ffha_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ffha_pkg::S_CLEAR;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    nxt_r  <= nxt_nxt;
    hlen_r <= hlen_nxt;
    req_r  <= req_nxt;
    if (out_valid_nxt) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign busy      = (state_r != ffha_pkg::S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  a_ok_not_corrupt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_item.ok && out_item.corrupt))
    else $error("result flags both ok and corrupt");

  a_start_only_on_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_item.chunk_start != 8'd0)) |-> out_item.ok)
    else $error("chunk start given on a failed command");

  a_wr_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (CW'(wr_addr) < HEAP_CW))
    else $error("store write outside the heap");

  a_multi_cycle_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_item.func == ffha_pkg::FUNC_ALLOC)) |=> busy && !out_valid)
    else $error("allocate finished without a walk");

endmodule
